FILE: design/uvlt_pkg.sv
// ----------------------------------------------------------------------------
// uvlt_pkg: shared types and codes for the unique value list table
// Field widths, command and status codes, and the controller states.
// ----------------------------------------------------------------------------
package uvlt_pkg;

  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SORT   = 3'd2,
    CMD_LIST   = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_FIND_CHK,
    S_SHIFT,
    S_SHIFT_WR,
    S_SORT_I,
    S_SORT_CUR,
    S_SORT_J,
    S_SORT_CMP,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESP
  } state_t;

endpackage

FILE: design/unique_value_list_table.sv
// ----------------------------------------------------------------------------
// unique_value_list_table: table of distinct signed values, new ones inserted at the front
// Insert/delete/search: scan the entries, move entries for insert/delete, then load the output reg.
// Sort: ascending insertion sort by compare/move of entries; list: each entry is read, then output.
// One request at a time (in_stall is high outside S_IDLE); the table memory has one read and one write port.
// Sync reset empties the table (fill count only, no clearing pass), returns to S_IDLE and clears out_valid.
// ----------------------------------------------------------------------------
module unique_value_list_table #(
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [uvlt_pkg::CMD_W-1:0]           command,
  input  logic signed [uvlt_pkg::DATA_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [uvlt_pkg::STATUS_W-1:0]        status,
  output logic [uvlt_pkg::POS_W-1:0]           position,
  output logic signed [uvlt_pkg::DATA_W-1:0]   entry_value,
  output logic                                 last
);
  import uvlt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t state, state_next;
  cmd_t   cmd;

  logic [CW-1:0] fill, fill_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] si, si_next;
  logic [CW-1:0] idx_inc, idx_dec, si_inc;

  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] cur, cur_next;

  logic [STATUS_W-1:0]      res_status, res_status_next;
  logic [POS_W-1:0]         res_pos, res_pos_next;
  logic signed [DATA_W-1:0] res_val, res_val_next;

  // table memory, registered read
  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic                     rd_en, wr_en;
  logic [AW-1:0]            rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  logic                     slot_free;
  logic                     out_load;
  logic [STATUS_W-1:0]      out_status_d;
  logic [POS_W-1:0]         out_pos_d;
  logic signed [DATA_W-1:0] out_val_d;
  logic                     out_last_d;
  logic                     hit;
  logic                     list_end;

  assign idx_inc   = idx + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign si_inc    = si + CW'(1);
  assign hit       = (rd_data == val);
  assign list_end  = (idx_inc == fill);
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_INSERT, CMD_DELETE, CMD_SEARCH: state_next = S_FIND;
            CMD_SORT:                           state_next = S_SORT_I;
            CMD_LIST: state_next = (fill == '0) ? S_RESP : S_LIST_RD;
            default:                            state_next = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (idx == fill) begin
          state_next = (cmd == CMD_INSERT && fill != FULL_CNT) ? S_SHIFT : S_RESP;
        end else begin
          state_next = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (hit) begin
          state_next = (cmd == CMD_DELETE) ? S_SHIFT : S_RESP;
        end else begin
          state_next = S_FIND;
        end
      end
      S_SHIFT: begin
        if (cmd == CMD_INSERT) begin
          state_next = (idx == '0) ? S_RESP : S_SHIFT_WR;
        end else begin
          state_next = list_end ? S_RESP : S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: state_next = S_SHIFT;
      S_SORT_I:   state_next = (si >= fill) ? S_RESP : S_SORT_CUR;
      S_SORT_CUR: state_next = S_SORT_J;
      S_SORT_J:   state_next = (idx == '0) ? S_SORT_I : S_SORT_CMP;
      S_SORT_CMP: state_next = (rd_data > cur) ? S_SORT_J : S_SORT_I;
      S_LIST_RD:  state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        if (slot_free) begin
          state_next = list_end ? S_IDLE : S_LIST_RD;
        end
      end
      S_RESP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory controls and datapath updates
  always_comb begin
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = cur;
    fill_next       = fill;
    idx_next        = idx;
    si_next         = si;
    cur_next        = cur;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    res_val_next    = res_val;
    out_load        = 1'b0;
    out_status_d    = res_status;
    out_pos_d       = res_pos;
    out_val_d       = res_val;
    out_last_d      = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next        = '0;
          si_next         = CW'(1);
          res_pos_next    = '0;
          res_val_next    = (command == CMD_DELETE) ? value : '0;
          res_status_next = (command == CMD_LIST && fill == '0) ? ST_EMPTY : ST_DONE;
        end
      end
      S_FIND: begin
        if (idx == fill) begin
          if (cmd == CMD_INSERT) begin
            if (fill == FULL_CNT) begin
              res_status_next = ST_FULL;
            end
          end else begin
            res_status_next = ST_NOTFOUND;
            res_val_next    = '0;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx[AW-1:0];
        end
      end
      S_FIND_CHK: begin
        if (hit) begin
          res_pos_next = POS_W'(idx);
          if (cmd == CMD_INSERT) begin
            res_status_next = ST_DUP;
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      S_SHIFT: begin
        if (cmd == CMD_INSERT) begin
          if (idx == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = val;
            fill_next = fill + CW'(1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_dec[AW-1:0];
          end
        end else begin
          if (list_end) begin
            fill_next = fill - CW'(1);
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
          end
        end
      end
      S_SHIFT_WR: begin
        wr_en    = 1'b1;
        wr_addr  = idx[AW-1:0];
        wr_data  = rd_data;
        idx_next = (cmd == CMD_INSERT) ? idx_dec : idx_inc;
      end
      S_SORT_I: begin
        if (si < fill) begin
          rd_en   = 1'b1;
          rd_addr = si[AW-1:0];
        end
      end
      S_SORT_CUR: begin
        cur_next = rd_data;
        idx_next = si;
      end
      S_SORT_J: begin
        if (idx == '0) begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = cur;
          si_next = si_inc;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
        end
      end
      S_SORT_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        if (rd_data > cur) begin
          wr_data  = rd_data;
          idx_next = idx_dec;
        end else begin
          wr_data = cur;
          si_next = si_inc;
        end
      end
      S_LIST_RD: begin
        rd_en   = 1'b1;
        rd_addr = idx[AW-1:0];
      end
      S_LIST_OUT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_status_d = ST_ENTRY;
          out_pos_d    = POS_W'(idx);
          out_val_d    = rd_data;
          out_last_d   = list_end;
          idx_next     = idx_inc;
        end
      end
      S_RESP: begin
        out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    si         <= si_next;
    cur        <= cur_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    res_val    <= res_val_next;
    if (state == S_IDLE && in_valid) begin
      cmd <= cmd_t'(command);
      val <= value;
    end
    if (out_load) begin
      status      <= out_status_d;
      position    <= out_pos_d;
      entry_value <= out_val_d;
      last        <= out_last_d;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count above table depth");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill != $past(fill)) |->
      (fill == $past(fill) + CW'(1)) || (fill == $past(fill) - CW'(1)))
    else $error("fill count moved by more than one");

  a_fill_src: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && fill != $past(fill)) |-> ($past(state) == S_SHIFT))
    else $error("fill count changed outside the shift step");
`endif

endmodule
